@@ src/aff3_pkg.sv @@
package aff3_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_BITS   = 12;
	localparam int OUT_BITS   = 32;

	// x*y - x*y of two coordinates
	localparam int COF_BITS = 2 * COORD_BITS + 1;
	// twice a triangle area, plus sign
	localparam int DET_BITS = 2 * COORD_BITS + 2;
	// three cofactor-by-target products
	localparam int NUM_BITS = COF_BITS + CFG_BITS + 3;
	localparam int REM_BITS = DET_BITS + 1;
	localparam int DIV_STEPS = OUT_BITS;
	localparam int INT_BITS  = OUT_BITS - FRAC_BITS;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(70);
	localparam logic [CFG_BITS-1:0] LENGTH_RESET = CFG_BITS'(100);

	typedef enum logic [0:0] {
		REG_FIELD_WIDTH  = 1'b0,
		REG_FIELD_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CORNER_0 = 2'd0,
		CORNER_1 = 2'd1,
		CORNER_2 = 2'd2,
		CORNER_3 = 2'd3
	} corner_t;

	typedef logic signed [COF_BITS-1:0] cof_t;
	typedef logic signed [DET_BITS-1:0] det_t;
	typedef logic signed [NUM_BITS-1:0] num_t;
	typedef logic        [NUM_BITS-1:0] nmag_t;
	typedef logic        [DET_BITS-1:0] dmag_t;
	typedef logic        [REM_BITS-1:0] rem_t;

	typedef struct packed {
		logic neg;
		logic ovf;
	} div_side_t;

endpackage

@@ src/aff3_div.sv @@
module aff3_div import aff3_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  nmag_t                      num,
	input  dmag_t                      den,
	input  div_side_t                  side,
	output logic signed [OUT_BITS-1:0] quo
);

	localparam int LAST = DIV_STEPS - 1;
	localparam logic [OUT_BITS:0] POS_LIM = {2'b00, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS:0] NEG_LIM = {2'b01, {(OUT_BITS-1){1'b0}}};

	rem_t                rem_s  [DIV_STEPS];
	dmag_t               den_s  [DIV_STEPS];
	logic [OUT_BITS-1:0] low_s  [DIV_STEPS];
	logic [OUT_BITS-1:0] q_s    [DIV_STEPS];
	div_side_t           side_s [DIV_STEPS];

	rem_t                rem_in  [DIV_STEPS];
	dmag_t               den_in  [DIV_STEPS];
	logic [OUT_BITS-1:0] low_in  [DIV_STEPS];
	logic [OUT_BITS-1:0] q_in    [DIV_STEPS];
	div_side_t           side_in [DIV_STEPS];
	rem_t                trial   [DIV_STEPS];
	rem_t                rem_nx  [DIV_STEPS];
	logic                ge      [DIV_STEPS];

	logic                rnd;
	logic [OUT_BITS:0]   mag;

	// numerator << FRAC_BITS: high part seeds the remainder, low bits stream in
	always_comb begin
		rem_in[0]  = REM_BITS'(num >> INT_BITS);
		low_in[0]  = OUT_BITS'({num, {FRAC_BITS{1'b0}}});
		q_in[0]    = '0;
		den_in[0]  = den;
		side_in[0] = side;
		for (int k = 1; k < DIV_STEPS; k++) begin
			rem_in[k]  = rem_s[k-1];
			low_in[k]  = low_s[k-1];
			q_in[k]    = q_s[k-1];
			den_in[k]  = den_s[k-1];
			side_in[k] = side_s[k-1];
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial[k]  = {rem_in[k][REM_BITS-2:0], low_in[k][OUT_BITS-1]};
			ge[k]     = trial[k] >= {1'b0, den_in[k]};
			rem_nx[k] = ge[k] ? trial[k] - {1'b0, den_in[k]} : trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_s[k]  <= rem_nx[k];
				den_s[k]  <= den_in[k];
				low_s[k]  <= {low_in[k][OUT_BITS-2:0], 1'b0};
				q_s[k]    <= {q_in[k][OUT_BITS-2:0], ge[k]};
				side_s[k] <= side_in[k];
			end
		end
	end

	// round half away from zero, then clamp to the signed range
	always_comb begin
		rnd = {rem_s[LAST], 1'b0} >= {2'b00, den_s[LAST]};
		mag = {1'b0, q_s[LAST]} + (OUT_BITS+1)'(rnd);
		if (side_s[LAST].neg) begin
			if (side_s[LAST].ovf || mag > NEG_LIM)
				quo = signed'({1'b1, {(OUT_BITS-1){1'b0}}});
			else
				quo = signed'(-mag[OUT_BITS-1:0]);
		end else begin
			if (side_s[LAST].ovf || mag > POS_LIM)
				quo = signed'({1'b0, {(OUT_BITS-1){1'b1}}});
			else
				quo = signed'(mag[OUT_BITS-1:0]);
		end
	end

endmodule

@@ src/affine_from_three_points.sv @@
// channel | direction | handshake            | beat
// in      | input     | in_valid / in_ready   | x1 y1 x2 y2 x3 y3 corner
// out     | output    | out_valid / out_ready | t00..t22 singular
// cfg     | input     | cfg_we                | cfg_idx cfg_wdata
//
// One beat enters per cycle while in_ready is high; the pipeline registers are cofactors,
// products, sums, magnitudes, then 32 restoring-divide stages (one quotient bit each) per
// element and the output register. The nine divider chains set the depth.
// Reset clears valid bits and loads field width 70, length 100.
// The whole pipeline advances when the output register is empty or taken;
// otherwise every stage holds and in_ready is low.
module affine_from_three_points import aff3_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [CFG_BITS-1:0]        cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [COORD_BITS-1:0]      x1,
	input  logic [COORD_BITS-1:0]      y1,
	input  logic [COORD_BITS-1:0]      x2,
	input  logic [COORD_BITS-1:0]      y2,
	input  logic [COORD_BITS-1:0]      x3,
	input  logic [COORD_BITS-1:0]      y3,
	input  logic [1:0]                 corner,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_BITS-1:0] t00,
	output logic signed [OUT_BITS-1:0] t01,
	output logic signed [OUT_BITS-1:0] t02,
	output logic signed [OUT_BITS-1:0] t10,
	output logic signed [OUT_BITS-1:0] t11,
	output logic signed [OUT_BITS-1:0] t12,
	output logic signed [OUT_BITS-1:0] t20,
	output logic signed [OUT_BITS-1:0] t21,
	output logic signed [OUT_BITS-1:0] t22,
	output logic                       singular
);

	localparam int LAST = DIV_STEPS - 1;

	logic [CFG_BITS-1:0] width_q, length_q;
	logic en;

	// stage 1
	logic                v_s1;
	cof_t                cof_s1 [3][3];
	logic [COORD_BITS-1:0] xa_s1, ya_s1;
	logic [CFG_BITS-1:0] bx_s1 [3];
	logic [CFG_BITS-1:0] by_s1 [3];
	// stage 2
	logic                v_s2;
	det_t                pdx_s2, pdy_s2;
	cof_t                cof_s2 [3][3];
	num_t                pc_s2 [3][3][2];
	// stage 3
	logic                v_s3;
	det_t                det_s3;
	num_t                c_s3 [3][3];
	// stage 4
	logic                v_s4, sing_s4;
	nmag_t               nmag_s4 [9];
	dmag_t               dmag_s4;
	div_side_t           side_s4 [9];
	// divider stages
	logic                v_div_s [DIV_STEPS];
	logic                sing_div_s [DIV_STEPS];
	// output
	logic                out_valid_q, sing_q;
	logic signed [OUT_BITS-1:0] t_q [9];
	logic signed [OUT_BITS-1:0] quo [9];

	logic [COORD_BITS-1:0] xs [3];
	logic [COORD_BITS-1:0] ys [3];
	cof_t                cof_c [3][3];
	logic [CFG_BITS-1:0] bx_c [3];
	logic [CFG_BITS-1:0] by_c [3];
	det_t                det_c;
	num_t                c_c [3][3];

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			length_q <= LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_FIELD_WIDTH:  width_q  <= cfg_wdata;
				REG_FIELD_LENGTH: length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// cofactors with the constant 1 column folded in
	always_comb begin
		xs[0] = x1; xs[1] = x2; xs[2] = x3;
		ys[0] = y1; ys[1] = y2; ys[2] = y3;
		for (int i = 0; i < 3; i++) begin
			cof_c[i][0] = cof_t'({1'b0, ys[(i+1)%3]}) - cof_t'({1'b0, ys[(i+2)%3]});
			cof_c[i][1] = cof_t'({1'b0, xs[(i+2)%3]}) - cof_t'({1'b0, xs[(i+1)%3]});
			cof_c[i][2] = cof_t'(xs[(i+1)%3] * ys[(i+2)%3])
			            - cof_t'(ys[(i+1)%3] * xs[(i+2)%3]);
		end
		bx_c[2] = length_q >> 1;
		by_c[2] = width_q >> 1;
		unique case (corner_t'(corner))
			CORNER_0: begin
				bx_c[0] = '0;       by_c[0] = width_q;
				bx_c[1] = length_q; by_c[1] = width_q;
			end
			CORNER_1: begin
				bx_c[0] = length_q; by_c[0] = width_q;
				bx_c[1] = length_q; by_c[1] = '0;
			end
			CORNER_2: begin
				bx_c[0] = length_q; by_c[0] = '0;
				bx_c[1] = '0;       by_c[1] = '0;
			end
			default: begin
				bx_c[0] = '0;       by_c[0] = '0;
				bx_c[1] = '0;       by_c[1] = width_q;
			end
		endcase
	end

	always_comb begin
		det_c = pdx_s2 + pdy_s2 + det_t'(cof_s2[0][2]);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 2; j++)
				c_c[i][j] = pc_s2[0][i][j] + pc_s2[1][i][j] + pc_s2[2][i][j];
			c_c[i][2] = num_t'(cof_s2[0][i]) + num_t'(cof_s2[1][i]) + num_t'(cof_s2[2][i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++)
				v_div_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_div_s[0] <= v_s4;
			for (int k = 1; k < DIV_STEPS; k++)
				v_div_s[k] <= v_div_s[k-1];
			out_valid_q <= v_div_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s1 <= cof_c;
			xa_s1  <= x1;
			ya_s1  <= y1;
			bx_s1  <= bx_c;
			by_s1  <= by_c;

			pdx_s2 <= det_t'(signed'({1'b0, xa_s1})) * det_t'(cof_s1[0][0]);
			pdy_s2 <= det_t'(signed'({1'b0, ya_s1})) * det_t'(cof_s1[0][1]);
			cof_s2 <= cof_s1;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					pc_s2[k][i][0] <= num_t'(cof_s1[k][i]) * num_t'(signed'({1'b0, bx_s1[k]}));
					pc_s2[k][i][1] <= num_t'(cof_s1[k][i]) * num_t'(signed'({1'b0, by_s1[k]}));
				end
			end

			det_s3 <= det_c;
			c_s3   <= c_c;

			sing_s4 <= det_s3 == '0;
			dmag_s4 <= det_s3[DET_BITS-1] ? dmag_t'(-det_s3) : dmag_t'(det_s3);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					nmag_s4[i*3+j] <= c_s3[i][j][NUM_BITS-1] ? nmag_t'(-c_s3[i][j])
					                                         : nmag_t'(c_s3[i][j]);
					side_s4[i*3+j].neg <= c_s3[i][j][NUM_BITS-1] ^ det_s3[DET_BITS-1];
					// integer part would not fit: |num| >= |det| << INT_BITS
					side_s4[i*3+j].ovf <=
						(c_s3[i][j][NUM_BITS-1] ? (NUM_BITS+OUT_BITS)'(nmag_t'(-c_s3[i][j]))
						                        : (NUM_BITS+OUT_BITS)'(nmag_t'(c_s3[i][j])))
						>= ((NUM_BITS+OUT_BITS)'(det_s3[DET_BITS-1] ? dmag_t'(-det_s3)
						                                            : dmag_t'(det_s3))
						    << INT_BITS);
				end
			end

			sing_div_s[0] <= sing_s4;
			for (int k = 1; k < DIV_STEPS; k++)
				sing_div_s[k] <= sing_div_s[k-1];

			sing_q <= sing_div_s[LAST];
			for (int e = 0; e < 9; e++)
				t_q[e] <= sing_div_s[LAST] ? '0 : quo[e];
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_div
		aff3_div u_div (
			.clk  (clk),
			.en   (en),
			.num  (nmag_s4[e]),
			.den  (dmag_s4),
			.side (side_s4[e]),
			.quo  (quo[e])
		);
	end

	assign out_valid = out_valid_q;
	assign singular  = sing_q;
	assign t00 = t_q[0];
	assign t01 = t_q[1];
	assign t02 = t_q[2];
	assign t10 = t_q[3];
	assign t11 = t_q[4];
	assign t12 = t_q[5];
	assign t20 = t_q[6];
	assign t21 = t_q[7];
	assign t22 = t_q[8];

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> t00 == '0 && t11 == '0 && t22 == '0 && t02 == '0)
		else $error("singular result with nonzero elements");

	a_rose_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_div_s[LAST]))
		else $error("result appeared without an item in the last divide stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(v_s4) && $stable(v_div_s[0]))
		else $error("pipeline moved during a stall");

endmodule
